// ===== rtl/tpq_pkg.sv =====
// ============================================================================
// tpq_pkg
// Shared types and constants for the timestamp priority request queue.
// ============================================================================
package tpq_pkg;

    // default sizes
    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 15;
    localparam int PID_BITS_DEF  = 4;

    // request kinds carried in s_tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    // result status codes carried in m_tuser
    typedef enum logic [1:0] {
        RES_DONE  = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2
    } res_code_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic      load_op;
        logic      exec;
        res_code_t code;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pop;
    } dp_stat_t;

endpackage

// ===== rtl/timestamp_priority_request_queue_top.sv =====
// ============================================================================
// timestamp_priority_request_queue_top
// Sorted request queue ordered by timestamp, ties by smaller process id.
// ============================================================================
// Each request word is accepted and latched in the idle state, then the
// exec state runs one compare-and-shift update across the cell row and loads
// the result register; no new word is taken until that update has run. The
// update waits while the result register still holds a word the sink has
// not taken. Every request gives one result word: status, the head entry
// after the step and the entry count. Inserts into a full queue and pops of
// an empty queue leave the queue as it was and are flagged.
module timestamp_priority_request_queue_top
    import tpq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int PID_BITS  = PID_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int SW       = ((TIME_BITS + PID_BITS + 7) / 8) * 8,
    localparam int MRAW     = 1 + TIME_BITS + PID_BITS + CW,
    localparam int MW       = ((MRAW + 7) / 8) * 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [SW-1:0] s_tdata,   // req_time, req_pid, zero pad
    input  logic          s_tuser,   // mode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [MW-1:0] m_tdata,   // head_valid, head_time, head_pid, count, zero pad
    output logic [1:0]    m_tuser    // status
);

    ctl_cmd_t             cmd;
    dp_stat_t             stat;
    res_code_t            res_status;
    logic                 res_head_valid;
    logic [TIME_BITS-1:0] res_head_time;
    logic [PID_BITS-1:0]  res_head_pid;
    logic [CW-1:0]        res_count;

    // sequencer
    tpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // cell row and result register
    tpq_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS),
        .PID_BITS  (PID_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_mode        (s_tuser),
        .in_time        (s_tdata[TIME_BITS-1:0]),
        .in_pid         (s_tdata[TIME_BITS +: PID_BITS]),
        .res_status     (res_status),
        .res_head_valid (res_head_valid),
        .res_head_time  (res_head_time),
        .res_head_pid   (res_head_pid),
        .res_count      (res_count)
    );

    // pack result word
    assign m_tdata = MW'({res_count, res_head_pid, res_head_time, res_head_valid});
    assign m_tuser = res_status;

endmodule

// ===== rtl/tpq_ctrl.sv =====
// ============================================================================
// tpq_ctrl
// Sequencer: takes one request word, runs one update of the cell array,
// and holds the result word valid until the sink takes it.
// ============================================================================
module tpq_ctrl
    import tpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;
    logic   slot_free;

    // output slot can take a new result
    assign slot_free = !valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs, with the result code from queue occupancy
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.load_op = 1'b0;
        cmd.exec    = 1'b0;
        if (stat.pop)
        begin
            cmd.code = stat.empty ? RES_EMPTY : RES_DONE;
        end
        else
        begin
            cmd.code = stat.full ? RES_FULL : RES_DONE;
        end
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_op = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.exec = slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (cmd.exec)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

// ===== rtl/tpq_datapath.sv =====
// ============================================================================
// tpq_datapath
// Row of compare-and-shift cells holding the sorted requests, the entry
// count, the latched request and the result register.
// ============================================================================
module tpq_datapath
    import tpq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int PID_BITS  = PID_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_cmd_t             cmd,
    output dp_stat_t             stat,
    input  logic                 in_mode,
    input  logic [TIME_BITS-1:0] in_time,
    input  logic [PID_BITS-1:0]  in_pid,
    output res_code_t            res_status,
    output logic                 res_head_valid,
    output logic [TIME_BITS-1:0] res_head_time,
    output logic [PID_BITS-1:0]  res_head_pid,
    output logic [CW-1:0]        res_count
);

    logic                 mode_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [PID_BITS-1:0]  pid_reg;

    logic [TIME_BITS-1:0] cell_time_reg [DEPTH];
    logic [TIME_BITS-1:0] cell_time_next [DEPTH];
    logic [PID_BITS-1:0]  cell_pid_reg [DEPTH];
    logic [PID_BITS-1:0]  cell_pid_next [DEPTH];
    logic [DEPTH-1:0]     lt;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 update;

    res_code_t            status_reg;
    logic                 head_valid_reg;
    logic [TIME_BITS-1:0] head_time_reg;
    logic [PID_BITS-1:0]  head_pid_reg;
    logic [CW-1:0]        count_out_reg;

    // latched request
    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            mode_reg <= in_mode;
            time_reg <= in_time;
            pid_reg  <= in_pid;
        end
    end

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.pop   = (mode_reg == MODE_POP);
    assign update     = cmd.exec && (cmd.code == RES_DONE);

    // per cell: new key sorts strictly before this valid entry
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic valid_here;
            logic prev_lt;

            assign valid_here = (CW'(i) < count_reg);
            assign lt[i] = valid_here &&
                ((time_reg < cell_time_reg[i]) ||
                 ((time_reg == cell_time_reg[i]) && (pid_reg < cell_pid_reg[i])));

            if (i == 0)
            begin : g_first
                assign prev_lt = 1'b0;
            end
            else
            begin : g_rest
                assign prev_lt = lt[i-1];
            end

            // next cell contents for insert and pop
            always_comb
            begin
                cell_time_next[i] = cell_time_reg[i];
                cell_pid_next[i]  = cell_pid_reg[i];
                if (update)
                begin
                    if (mode_reg == MODE_POP)
                    begin
                        if (i < DEPTH - 1)
                        begin
                            cell_time_next[i] = cell_time_reg[(i + 1) % DEPTH];
                            cell_pid_next[i]  = cell_pid_reg[(i + 1) % DEPTH];
                        end
                    end
                    else if (CW'(i) <= count_reg)
                    begin
                        if (prev_lt)
                        begin
                            cell_time_next[i] = cell_time_reg[(i + DEPTH - 1) % DEPTH];
                            cell_pid_next[i]  = cell_pid_reg[(i + DEPTH - 1) % DEPTH];
                        end
                        else if (lt[i] || !valid_here)
                        begin
                            cell_time_next[i] = time_reg;
                            cell_pid_next[i]  = pid_reg;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                cell_time_reg[i] <= cell_time_next[i];
                cell_pid_reg[i]  <= cell_pid_next[i];
            end
        end
    endgenerate

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (update)
        begin
            if (mode_reg == MODE_POP)
            begin
                count_next = count_reg - CW'(1);
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // result word from the state after the step
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg     <= cmd.code;
            head_valid_reg <= (count_next != '0);
            head_time_reg  <= (count_next != '0) ? cell_time_next[0] : '0;
            head_pid_reg   <= (count_next != '0) ? cell_pid_next[0] : '0;
            count_out_reg  <= count_next;
        end
    end

    assign res_status     = status_reg;
    assign res_head_valid = head_valid_reg;
    assign res_head_time  = head_time_reg;
    assign res_head_pid   = head_pid_reg;
    assign res_count      = count_out_reg;

endmodule

// ===== rtl/tpq_checker.sv =====
// ============================================================================
// tpq_checker
// Port-level checks on the request queue's result words.
// ============================================================================
module tpq_checker
    import tpq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int PID_BITS  = PID_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int MRAW     = 1 + TIME_BITS + PID_BITS + CW,
    localparam int MW       = ((MRAW + 7) / 8) * 8,
    localparam int CNT_LO   = 1 + TIME_BITS + PID_BITS
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [MW-1:0] m_tdata,
    input logic [1:0]    m_tuser
);

    logic [CW-1:0] cnt;
    logic          hv;

    assign cnt = m_tdata[CNT_LO +: CW];
    assign hv  = m_tdata[0];

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // count never exceeds depth, head flag matches count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cnt <= CW'(DEPTH)) && (hv == (cnt != '0)))
        else $error("count or head flag inconsistent");

    // dropped insert only when full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == RES_FULL) |-> (cnt == CW'(DEPTH)))
        else $error("full status with room left");

    // ignored pop only when empty
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == RES_EMPTY) |-> (cnt == '0) && !hv)
        else $error("empty status with entries queued");

    // one result per request: no new request taken in the cycle after one
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken before previous one was processed");

endmodule

bind timestamp_priority_request_queue_top tpq_checker #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS),
    .PID_BITS  (PID_BITS)
) u_tpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
